// ===== rtl/lru_k_block_cache_defines.svh =====
// Assertion macros shared by the LRU-K block cache RTL.
// No dependencies; included by files that carry assertions.
`ifndef LRU_K_BLOCK_CACHE_DEFINES_SVH
`define LRU_K_BLOCK_CACHE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define LKC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define LKC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== rtl/lkc_pkg.sv =====
// Package for the LRU-K block cache: sizes, payload structs, FSM states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lkc_pkg;
    localparam int CAPACITY = 32;
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CFG_W = 8;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_K_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY_LIMIT = 1'd1;
    localparam int ENT_W = 32 + 32 + 32 + 8 + IDX_W;

    typedef struct packed {
        logic        mode;
        logic [31:0] sst_id;
        logic [31:0] block_no;
        logic [31:0] data_ref;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic [31:0] hit_data_ref;
        logic        evicted;
        logic [31:0] evicted_sst_id;
        logic [31:0] evicted_block_no;
        logic [31:0] request_total;
        logic [31:0] hit_total;
    } t_rsp;

    typedef struct packed {
        logic [31:0]      sst;
        logic [31:0]      blk;
        logic [31:0]      handle;
        logic [7:0]       uses;
        logic [IDX_W-1:0] rank;
    } t_entry;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_DECIDE = 5'b00100,
        ST_UPDATE = 5'b01000,
        ST_DONE   = 5'b10000
    } t_state;
endpackage
`default_nettype wire

// ===== rtl/lkc_ram.sv =====
// Generic single-port-write, single-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module lkc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/lru_k_block_cache.sv =====
// LRU-K block cache top level: sequencer around one entry RAM.
// Depends on lkc_pkg, lkc_ram and lru_k_block_cache_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "lru_k_block_cache_defines.svh"
// Fully associative LRU-K cache of CAPACITY entries keyed by (sst id, block
// id). Raise start with a request while busy is low; busy then stays high
// until the request is finished and the result appears in the cycle after, for
// one cycle with o_done, and must be captured then. The next request can be
// taken in that same cycle. The work is done in two passes: one streams every
// entry from the entry RAM to find the key, the occupancy and the eviction
// victim, and a second reads, adjusts and writes back the recency rank of every
// valid entry, one entry a cycle through the RAM's single write port; a decide
// state sits between them and a finish state follows. Valid bits sit in
// flip-flops and clear at reset, so there is no clearing pass. Configuration
// writes are taken at any time but should only be made while busy is low.
module lru_k_block_cache
    import lkc_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  start,
    output logic                 busy,
    input  wire t_req            i_req,
    output logic                 o_done,
    output t_rsp                 o_rsp,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [CFG_W-1:0]      i_cfg_data
);
    t_state r_state, n_state;
    logic [CAPACITY-1:0] r_valid, n_valid;
    logic [7:0] r_k;
    logic [5:0] r_cap;
    t_req r_req;
    logic [31:0] r_lookups, r_hits;

    // Scan bookkeeping
    logic [IDX_W:0] r_rd;                 // read pointer
    logic r_rv;                           // read data valid this cycle
    logic [IDX_W-1:0] r_ri;               // index of data in flight
    logic r_found; logic [IDX_W-1:0] r_fidx; t_entry r_fent;
    logic [CNT_W-1:0] r_count;
    logic r_cold, r_hot;
    logic [IDX_W-1:0] r_cidx, r_hidx, r_crank, r_hrank;
    t_entry r_cent, r_hent;
    // Decision
    logic r_do_touch, r_do_ins, r_do_ev;
    logic [IDX_W-1:0] r_tidx, r_vrank, r_trank, r_slot, r_vidx;
    logic r_has_slot;

    // RAM port
    logic ram_we;
    logic [IDX_W-1:0] ram_wa, ram_ra;
    t_entry ram_wd, ram_rd;

    lkc_ram #(.WIDTH(ENT_W), .DEPTH(CAPACITY)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_wa),
        .i_wdata(ram_wd),
        .i_raddr(ram_ra),
        .o_rdata(ram_rd)
    );

    logic [7:0] k_eff;
    logic [CNT_W-1:0] cap_eff;
    assign k_eff = (r_k < 8'd2) ? 8'd2 : r_k;
    always_comb begin
        if (r_cap == 6'd0) cap_eff = CNT_W'(1);
        else if (CNT_W'(r_cap) > CNT_W'(CAPACITY)) cap_eff = CNT_W'(CAPACITY);
        else cap_eff = CNT_W'(r_cap);
    end

    assign busy = (r_state != ST_IDLE);
    assign ram_ra = r_rd[IDX_W-1:0];

    // Write-back value of one entry in the update pass
    t_entry upd;
    logic upd_we;
    always_comb begin
        upd = ram_rd;
        upd_we = 1'b0;
        if (r_rv && r_valid[r_ri]) begin
            upd_we = 1'b1;
            if (r_do_touch) begin
                if (r_ri == r_tidx) begin
                    upd.rank = '0;
                    if (ram_rd.uses != 8'hFF) upd.uses = ram_rd.uses + 8'd1;
                    if (r_req.mode) upd.handle = r_req.data_ref;
                end else if (ram_rd.rank < r_trank) begin
                    upd.rank = ram_rd.rank + 1'b1;
                end
            end else if (r_do_ins) begin
                if (r_do_ev && ram_rd.rank > r_vrank) upd.rank = ram_rd.rank;
                else upd.rank = ram_rd.rank + 1'b1;
            end
        end
    end

    always_comb begin
        ram_we = 1'b0;
        ram_wa = r_ri;
        ram_wd = upd;
        n_state = r_state;
        n_valid = r_valid;
        case (r_state)
            ST_IDLE:   if (start) n_state = ST_SCAN;
            ST_SCAN:   if (r_rv && r_ri == IDX_W'(CAPACITY - 1)) n_state = ST_DECIDE;
            ST_DECIDE: n_state = ST_UPDATE;
            ST_UPDATE: begin
                ram_we = upd_we;
                if (r_rv && r_ri == IDX_W'(CAPACITY - 1)) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (r_do_ins) begin
                    if (r_do_ev) n_valid[r_vidx] = 1'b0;
                    if (r_has_slot) begin
                        n_valid[r_slot] = 1'b1;
                        ram_we = 1'b1;
                        ram_wa = r_slot;
                        ram_wd.sst = r_req.sst_id;
                        ram_wd.blk = r_req.block_no;
                        ram_wd.handle = r_req.data_ref;
                        ram_wd.uses = 8'd1;
                        ram_wd.rank = '0;
                    end
                end
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= '0;
            r_k <= 8'd2;
            r_cap <= 6'd32;
            r_lookups <= '0;
            r_hits <= '0;
            r_rv <= 1'b0;
            r_rd <= '0;
            o_done <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            o_done <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_K_THRESHOLD) r_k <= i_cfg_data;
                else if (i_cfg_idx == CFG_CAPACITY_LIMIT) r_cap <= i_cfg_data[5:0];
            end
            // Stream reads through the RAM during both passes
            r_rv <= 1'b0;
            if ((r_state == ST_IDLE && start) || r_state == ST_DECIDE) begin
                r_rd <= '0;
            end else if ((r_state == ST_SCAN || r_state == ST_UPDATE)
                         && r_rd != (IDX_W+1)'(CAPACITY)) begin
                r_rv <= 1'b1;
                r_rd <= r_rd + 1'b1;
            end
            if (r_state == ST_DONE) begin
                o_done <= 1'b1;
                if (!r_req.mode) begin
                    if (r_lookups != '1) r_lookups <= r_lookups + 32'd1;
                    if (r_found && r_hits != '1) r_hits <= r_hits + 32'd1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_ri <= r_rd[IDX_W-1:0];
        case (r_state)
            ST_IDLE: begin
                r_req <= i_req;
                r_found <= 1'b0; r_count <= '0; r_cold <= 1'b0; r_hot <= 1'b0;
                r_has_slot <= 1'b0;
            end
            ST_SCAN: begin
                if (r_rv && r_valid[r_ri]) begin
                    r_count <= r_count + 1'b1;
                    if (!r_found && ram_rd.sst == r_req.sst_id
                        && ram_rd.blk == r_req.block_no) begin
                        r_found <= 1'b1; r_fidx <= r_ri; r_fent <= ram_rd;
                    end
                    if (ram_rd.uses < k_eff) begin
                        if (!r_cold || ram_rd.rank > r_crank) begin
                            r_cold <= 1'b1; r_cidx <= r_ri; r_crank <= ram_rd.rank;
                            r_cent <= ram_rd;
                        end
                    end else if (!r_hot || ram_rd.rank > r_hrank) begin
                        r_hot <= 1'b1; r_hidx <= r_ri; r_hrank <= ram_rd.rank;
                        r_hent <= ram_rd;
                    end
                end
                if (r_rv && !r_valid[r_ri] && !r_has_slot) begin
                    r_has_slot <= 1'b1; r_slot <= r_ri;
                end
            end
            ST_DECIDE: begin
                r_do_touch <= r_found;
                r_tidx <= r_fidx;
                r_trank <= r_fent.rank;
                r_do_ins <= r_req.mode && !r_found;
                r_do_ev <= r_req.mode && !r_found && r_count >= cap_eff
                           && (r_cold || r_hot);
                r_vidx <= r_cold ? r_cidx : r_hidx;
                r_vrank <= r_cold ? r_crank : r_hrank;
                if (r_req.mode && !r_found && r_count >= cap_eff && (r_cold || r_hot)
                    && !r_has_slot) begin
                    r_has_slot <= 1'b1;
                    r_slot <= r_cold ? r_cidx : r_hidx;
                end
            end
            ST_UPDATE: begin
                // The victim is re-ranked like the others; it is dropped at the end
                if (r_rv && r_do_ev && r_ri == r_vidx) begin
                end
            end
            default: begin
            end
        endcase
        if (r_state == ST_DONE) begin
            o_rsp.hit <= r_found;
            o_rsp.hit_data_ref <= (!r_req.mode && r_found) ? r_fent.handle : 32'd0;
            o_rsp.evicted <= r_do_ev;
            o_rsp.evicted_sst_id <= r_do_ev ? (r_cold ? r_cent.sst : r_hent.sst) : 32'd0;
            o_rsp.evicted_block_no <= r_do_ev ? (r_cold ? r_cent.blk : r_hent.blk) : 32'd0;
            o_rsp.request_total <= (!r_req.mode && r_lookups != '1)
                                   ? r_lookups + 32'd1 : r_lookups;
            o_rsp.hit_total <= (!r_req.mode && r_found && r_hits != '1)
                               ? r_hits + 32'd1 : r_hits;
        end
    end

    `LKC_ASSERT_IMPL(a_done_one_cycle, i_clk, i_rst_n, o_done, !$past(o_done), "done held")
    `LKC_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy, "start not taken")
    `LKC_ASSERT_IMPL(a_ev_put, i_clk, i_rst_n, o_done && o_rsp.evicted, !o_rsp.hit,
                     "eviction on hit")
    `LKC_ASSERT_IMPL(a_no_write_idle, i_clk, i_rst_n, r_state == ST_IDLE, !ram_we,
                     "RAM write while idle")
endmodule
`default_nettype wire
